/* rtl/tbs_pkg.sv */
// shared types and constants for the tiling box splitter
package tbs_pkg;
    localparam int unsigned MaxViewsDefault = 64;
    localparam int unsigned CoordW = 15;
    localparam int unsigned BoxW = 16;
    localparam int unsigned CountW = 7;
    localparam int unsigned DivW = 32;

    localparam logic [1:0] ModeEven = 2'd0;
    localparam logic [1:0] ModeDiminish = 2'd1;
    localparam logic [1:0] ModeDwindle = 2'd2;

    localparam logic [1:0] DirN = 2'd0;
    localparam logic [1:0] DirE = 2'd1;
    localparam logic [1:0] DirS = 2'd2;
    localparam logic [1:0] DirW = 2'd3;

    typedef struct packed {
        logic load;
        logic start_w;
        logic start_h;
        logic cut;
        logic emit;
    } tbs_cmd_t;

    typedef struct packed {
        logic div_busy;
        logic last;
        logic done;
        logic out_full;
    } tbs_stat_t;
endpackage

/* rtl/tiling_box_splitter_core.sv */
// top level of the tiling box splitter: apb register, sequencer and datapath
// One request beat carves its rectangle into min(remaining_count, MAX_VIEWS)
// boxes, each sent as one result beat, last_box set on the final one. A
// request with total_count or remaining_count zero gives no beat. Every box
// except the last sizes both axes with a half-up rounded quotient from one
// shared restoring divider at one quotient bit per cycle, passing through a start
// state, the width division, the height division and an emit state that waits
// while the output register is full; the last box skips the divisions.
// The next request is taken only once the previous one has sent its last box
// into the output register. stack_mode sits at byte address 0 (0 even,
// 1 diminish, 2 dwindle, 3 acts as even) and may be written only while idle.
module tiling_box_splitter_core #(
    parameter int unsigned MAX_VIEWS = tbs_pkg::MaxViewsDefault
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [1:0]                  paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic [tbs_pkg::CoordW-1:0]  area_x,
    input  logic [tbs_pkg::CoordW-1:0]  area_y,
    input  logic [tbs_pkg::CoordW-1:0]  area_width,
    input  logic [tbs_pkg::CoordW-1:0]  area_height,
    input  logic [tbs_pkg::CoordW-1:0]  total_width,
    input  logic [tbs_pkg::CoordW-1:0]  total_height,
    input  logic [tbs_pkg::CountW-1:0]  total_count,
    input  logic [tbs_pkg::CountW-1:0]  remaining_count,
    input  logic [1:0]                  first_direction,
    input  logic [1:0]                  second_direction,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic [tbs_pkg::BoxW-1:0]    box_x,
    output logic [tbs_pkg::BoxW-1:0]    box_y,
    output logic [tbs_pkg::CoordW-1:0]  box_width,
    output logic [tbs_pkg::CoordW-1:0]  box_height,
    output logic                        last_box
);
    import tbs_pkg::*;

    localparam logic [1:0] AddrMode = 2'd0;

    logic [1:0]  mode_reg;
    tbs_cmd_t    cmd;
    tbs_stat_t   stat;
    logic        req_empty;

    // single config register, written on the apb access phase
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            mode_reg <= ModeEven;
        else if (psel && penable && pwrite && paddr == AddrMode)
            mode_reg <= pwdata[1:0];
    end

    assign pready = 1'b1;
    assign prdata = (paddr == AddrMode) ? {30'd0, mode_reg} : 32'd0;

    // zero counts produce no boxes at all
    assign req_empty = (total_count == '0) || (remaining_count == '0);

    tbs_control u_ctrl (
        .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
        .req_empty(req_empty), .cmd(cmd), .stat(stat)
    );

    tbs_datapath #(.MAX_VIEWS(MAX_VIEWS)) u_dp (
        .clk(clk), .rst_n(rst_n), .cmd(cmd), .stat(stat), .stack_mode(mode_reg),
        .area_x(area_x), .area_y(area_y), .area_width(area_width),
        .area_height(area_height), .total_width(total_width),
        .total_height(total_height), .total_count(total_count),
        .remaining_count(remaining_count), .first_direction(first_direction),
        .second_direction(second_direction), .out_valid(out_valid),
        .out_ready(out_ready), .box_x(box_x), .box_y(box_y),
        .box_width(box_width), .box_height(box_height), .last_box(last_box)
    );
endmodule

/* rtl/tbs_divider.sv */
// restoring divider, one quotient bit per cycle
module tbs_divider (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    input  logic [tbs_pkg::DivW-1:0]  dividend,
    input  logic [tbs_pkg::DivW-1:0]  divisor,
    output logic                      busy,
    output logic [tbs_pkg::DivW-1:0]  quotient
);
    import tbs_pkg::*;

    logic [DivW-1:0] q_reg, q_next;
    logic [DivW-1:0] r_reg, r_next;
    logic [DivW-1:0] d_reg, d_next;
    logic [5:0]      cnt_reg, cnt_next;
    logic            busy_reg, busy_next;
    logic [DivW:0]   trial;

    always_comb
    begin
        q_next = q_reg;
        r_next = r_reg;
        d_next = d_reg;
        cnt_next = cnt_reg;
        busy_next = busy_reg;
        trial = {r_reg, q_reg[DivW-1]} - {1'b0, d_reg};
        if (start)
        begin
            q_next = dividend;
            r_next = '0;
            d_next = divisor;
            cnt_next = 6'(DivW);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (!trial[DivW])
            begin
                r_next = trial[DivW-1:0];
                q_next = {q_reg[DivW-2:0], 1'b1};
            end
            else
            begin
                r_next = {r_reg[DivW-2:0], q_reg[DivW-1]};
                q_next = {q_reg[DivW-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 6'd1;
            if (cnt_reg == 6'd1)
                busy_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg <= q_next;
        r_reg <= r_next;
        d_reg <= d_next;
    end

    assign busy = busy_reg;
    assign quotient = q_reg;
endmodule

/* rtl/tbs_datapath.sv */
// rectangle registers, cut arithmetic and output register
module tbs_datapath #(
    parameter int unsigned MAX_VIEWS = tbs_pkg::MaxViewsDefault
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  tbs_pkg::tbs_cmd_t           cmd,
    output tbs_pkg::tbs_stat_t          stat,
    input  logic [1:0]                  stack_mode,
    input  logic [tbs_pkg::CoordW-1:0]  area_x,
    input  logic [tbs_pkg::CoordW-1:0]  area_y,
    input  logic [tbs_pkg::CoordW-1:0]  area_width,
    input  logic [tbs_pkg::CoordW-1:0]  area_height,
    input  logic [tbs_pkg::CoordW-1:0]  total_width,
    input  logic [tbs_pkg::CoordW-1:0]  total_height,
    input  logic [tbs_pkg::CountW-1:0]  total_count,
    input  logic [tbs_pkg::CountW-1:0]  remaining_count,
    input  logic [1:0]                  first_direction,
    input  logic [1:0]                  second_direction,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic [tbs_pkg::BoxW-1:0]    box_x,
    output logic [tbs_pkg::BoxW-1:0]    box_y,
    output logic [tbs_pkg::CoordW-1:0]  box_width,
    output logic [tbs_pkg::CoordW-1:0]  box_height,
    output logic                        last_box
);
    import tbs_pkg::*;

    localparam int unsigned NW = $clog2(MAX_VIEWS + 1) > CountW ?
                                 $clog2(MAX_VIEWS + 1) : CountW;

    logic [BoxW-1:0]   rx_reg, ry_reg;
    logic [CoordW-1:0] rw_reg, rh_reg, tw_reg, th_reg;
    logic [12:0]       den_reg;
    logic [NW-1:0]     n_reg;
    logic [1:0]        dc_reg, dn_reg;
    logic [CoordW-1:0] cw_reg, ch_reg;
    logic              ov_reg;
    logic [BoxW-1:0]   ox_reg, oy_reg;
    logic [CoordW-1:0] ow_reg, oh_reg;
    logic              ol_reg;

    logic              div_start, div_busy;
    logic [DivW-1:0]   div_a, div_d, div_q;
    logic [DivW-1:0]   num, dsr;
    logic [CoordW-1:0] ext, tot, qc, cw, ch;
    logic [13:0]       tri_full;

    assign tri_full = 14'(total_count) * (14'(total_count) + 14'd1);

    // numerator a and divisor d for the axis being sized
    always_comb
    begin
        ext = cmd.start_h ? rh_reg : rw_reg;
        tot = cmd.start_h ? th_reg : tw_reg;
        case (stack_mode)
            ModeDiminish:
            begin
                num = 32'(n_reg) * 32'(tot);
                dsr = 32'(den_reg);
            end
            ModeDwindle:
            begin
                num = 32'(ext);
                dsr = 32'd2;
            end
            default:
            begin
                num = 32'(ext);
                dsr = 32'(n_reg);
            end
        endcase
        div_a = (num << 1) + dsr;
        div_d = dsr << 1;
    end
    assign div_start = cmd.start_w | cmd.start_h;

    tbs_divider u_div (
        .clk(clk), .rst_n(rst_n), .start(div_start), .dividend(div_a),
        .divisor(div_d), .busy(div_busy), .quotient(div_q)
    );

    assign qc = (div_q > 32'(rw_reg)) ? rw_reg : div_q[CoordW-1:0];
    assign cw = cw_reg;
    assign ch = ch_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            ov_reg <= 1'b0;
        else if (cmd.emit)
            ov_reg <= 1'b1;
        else if (out_ready)
            ov_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            rx_reg <= BoxW'(area_x);
            ry_reg <= BoxW'(area_y);
            rw_reg <= area_width;
            rh_reg <= area_height;
            tw_reg <= total_width;
            th_reg <= total_height;
            den_reg <= tri_full[13:1];
            n_reg <= (remaining_count > NW'(MAX_VIEWS)) ? NW'(MAX_VIEWS)
                                                         : NW'(remaining_count);
            dc_reg <= first_direction;
            dn_reg <= second_direction;
        end
        // capture clamped quotients when the divider has finished
        if (cmd.start_h)
            cw_reg <= qc;
        if (cmd.cut)
            ch_reg <= (div_q > 32'(rh_reg)) ? rh_reg : div_q[CoordW-1:0];
        if (cmd.emit)
        begin
            ox_reg <= rx_reg;
            oy_reg <= ry_reg;
            ow_reg <= rw_reg;
            oh_reg <= rh_reg;
            ol_reg <= (n_reg == NW'(1));
            if (n_reg != NW'(1))
            begin
                case (dc_reg)
                    DirN:
                    begin
                        oh_reg <= ch;
                        oy_reg <= ry_reg + BoxW'(rh_reg - ch);
                        rh_reg <= rh_reg - ch;
                    end
                    DirS:
                    begin
                        oh_reg <= ch;
                        ry_reg <= ry_reg + BoxW'(ch);
                        rh_reg <= rh_reg - ch;
                    end
                    DirE:
                    begin
                        ow_reg <= cw;
                        rx_reg <= rx_reg + BoxW'(cw);
                        rw_reg <= rw_reg - cw;
                    end
                    default:
                    begin
                        ow_reg <= cw;
                        ox_reg <= rx_reg + BoxW'(rw_reg - cw);
                        rw_reg <= rw_reg - cw;
                    end
                endcase
                if (stack_mode == ModeDwindle)
                begin
                    dc_reg <= dn_reg;
                    dn_reg <= dc_reg;
                end
            end
            n_reg <= n_reg - NW'(1);
        end
    end

    assign stat.div_busy = div_busy;
    assign stat.last = (n_reg == NW'(1));
    assign stat.done = (n_reg == '0);
    assign stat.out_full = ov_reg & ~out_ready;

    assign out_valid = ov_reg;
    assign box_x = ox_reg;
    assign box_y = oy_reg;
    assign box_width = ow_reg;
    assign box_height = oh_reg;
    assign last_box = ol_reg;
endmodule

/* rtl/tbs_control.sv */
// sequencer stepping one box at a time through the shared divider
module tbs_control (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic                req_empty,
    output tbs_pkg::tbs_cmd_t   cmd,
    input  tbs_pkg::tbs_stat_t  stat
);
    import tbs_pkg::*;

    localparam logic [2:0] StIdle = 3'd0;
    localparam logic [2:0] StStartW = 3'd1;
    localparam logic [2:0] StWaitW = 3'd2;
    localparam logic [2:0] StWaitH = 3'd3;
    localparam logic [2:0] StEmit = 3'd4;

    logic [2:0] st_reg, st_next;

    assign in_ready = (st_reg == StIdle);

    always_comb
    begin
        st_next = st_reg;
        cmd = '0;
        case (st_reg)
            StIdle:
            begin
                if (in_valid)
                begin
                    cmd.load = ~req_empty;
                    st_next = req_empty ? StIdle : StStartW;
                end
            end
            StStartW:
            begin
                if (stat.done)
                    st_next = StIdle;
                else if (stat.last)
                    st_next = StEmit;
                else
                begin
                    cmd.start_w = 1'b1;
                    st_next = StWaitW;
                end
            end
            StWaitW:
            begin
                if (!stat.div_busy)
                begin
                    cmd.start_h = 1'b1;
                    st_next = StWaitH;
                end
            end
            StWaitH:
            begin
                if (!stat.div_busy)
                begin
                    cmd.cut = 1'b1;
                    st_next = StEmit;
                end
            end
            StEmit:
            begin
                if (!stat.out_full)
                begin
                    cmd.emit = 1'b1;
                    st_next = StStartW;
                end
            end
            default: st_next = StIdle;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            st_reg <= StIdle;
        else
            st_reg <= st_next;
    end
endmodule

/* tb/sv/tb_tiling_box_splitter_core.sv */
// testbench for the tiling box splitter: directed and random requests checked against a box predictor
module tb_tiling_box_splitter_core;
    import tbs_pkg::*;

    localparam int unsigned NumRandom = 150;
    localparam int unsigned StallLimit = 200000;
    localparam int HoldCycles = 3000;
    localparam logic [1:0] RegStackMode = 2'd0;

    typedef struct packed {
        logic [14:0] ax, ay, aw, ah, tw, th;
        logic [6:0]  ntot, nrem;
        logic [1:0]  d0, d1;
    } req_t;

    typedef struct packed {
        logic [15:0] bx, by;
        logic [14:0] bw, bh;
        logic        lst;
    } box_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [1:0] paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic pready;
    logic in_valid = 1'b0;
    logic in_ready;
    req_t cur = '0;
    logic out_valid;
    logic out_ready = 1'b0;
    logic [15:0] box_x, box_y;
    logic [14:0] box_width, box_height;
    logic last_box;

    always #5 clk = ~clk;

    tiling_box_splitter_core i_dut (
        .clk, .rst_n, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
        .in_valid, .in_ready,
        .area_x(cur.ax), .area_y(cur.ay), .area_width(cur.aw), .area_height(cur.ah),
        .total_width(cur.tw), .total_height(cur.th), .total_count(cur.ntot),
        .remaining_count(cur.nrem), .first_direction(cur.d0), .second_direction(cur.d1),
        .out_valid, .out_ready, .box_x, .box_y, .box_width, .box_height, .last_box
    );

    req_t pending_reqs[$];
    box_t expected_boxes[$];
    logic [1:0] mode_shadow = ModeEven;
    int errors = 0;
    int boxes_seen = 0;
    int reqs_sent = 0;
    int idle_cycles = 0;
    int hold_reqs = 0;
    int hold_seen = 0;
    int hold_left = 0;

    // half-up rounded quotient, d never zero
    function automatic longint unsigned round_div(longint unsigned a, longint unsigned d);
        return (2 * a + d) / (2 * d);
    endfunction

    // carve one request into boxes and queue them
    function automatic void carve_boxes(req_t r);
        longint unsigned rx, ry, rw, rh, cw, ch, left, tri_sum;
        logic [1:0] dc, dn, t;
        box_t b;
        rx = r.ax; ry = r.ay; rw = r.aw; rh = r.ah;
        dc = r.d0; dn = r.d1;
        left = r.nrem;
        tri_sum = r.ntot * (r.ntot + 1) / 2;
        if (r.ntot == 0 || r.nrem == 0)
            return;
        if (left > MaxViewsDefault)
            left = MaxViewsDefault;
        while (left > 0)
        begin
            b.bx = rx[15:0]; b.by = ry[15:0]; b.bw = rw[14:0]; b.bh = rh[14:0];
            b.lst = (left == 1);
            if (left != 1)
            begin
                if (mode_shadow == ModeDiminish)
                begin
                    cw = round_div(left * r.tw, tri_sum);
                    ch = round_div(left * r.th, tri_sum);
                end
                else if (mode_shadow == ModeDwindle)
                begin
                    cw = round_div(rw, 2);
                    ch = round_div(rh, 2);
                end
                else
                begin
                    cw = round_div(rw, left);
                    ch = round_div(rh, left);
                end
                if (cw > rw) cw = rw;
                if (ch > rh) ch = rh;
                case (dc)
                    DirN:
                    begin
                        b.bh = ch[14:0];
                        b.by = 16'(ry + rh - ch);
                        rh -= ch;
                    end
                    DirS:
                    begin
                        b.bh = ch[14:0];
                        ry += ch;
                        rh -= ch;
                    end
                    DirE:
                    begin
                        b.bw = cw[14:0];
                        rx += cw;
                        rw -= cw;
                    end
                    default:
                    begin
                        b.bw = cw[14:0];
                        b.bx = 16'(rx + rw - cw);
                        rw -= cw;
                    end
                endcase
                if (mode_shadow == ModeDwindle)
                begin
                    t = dc; dc = dn; dn = t;
                end
            end
            expected_boxes.push_back(b);
            left--;
        end
    endfunction

    // mostly short gaps, now and then a long one
    function automatic int gap_len();
        int p;
        p = $urandom_range(99);
        if (p < 55) return 0;
        if (p < 92) return $urandom_range(3, 1);
        return $urandom_range(60, 10);
    endfunction

    // mostly small counts so runs stay short, few full-size ones
    function automatic req_t rand_req();
        req_t r;
        int p;
        r = req_t'(108'({$urandom, $urandom, $urandom, $urandom}));
        p = $urandom_range(99);
        if (p < 70) r.nrem = 7'($urandom_range(8, 1));
        else if (p < 85) r.nrem = 7'($urandom_range(64, 9));
        else if (p < 95) r.nrem = 7'($urandom_range(127, 65));
        else r.nrem = 7'($urandom_range(1, 0));
        p = $urandom_range(99);
        if (p < 80) r.ntot = 7'($urandom_range(64, 1));
        else if (p < 95) r.ntot = 7'($urandom_range(127, 65));
        else r.ntot = 7'd0;
        return r;
    endfunction

    // driver: presents queued requests with random gaps
    int drv_gap = 0;
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && in_ready)
            begin
                reqs_sent++;
                carve_boxes(cur);
            end
            if (!in_valid || in_ready)
            begin
                if (drv_gap > 0)
                begin
                    drv_gap <= drv_gap - 1;
                    in_valid <= 1'b0;
                end
                else if (pending_reqs.size() > 0)
                begin
                    cur <= pending_reqs.pop_front();
                    in_valid <= 1'b1;
                    drv_gap <= gap_len();
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // monitor: compares each box beat against the oldest expected box
    int rdy_gap = 0;
    always @(posedge clk)
    begin
        box_t e;
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                boxes_seen++;
                if (expected_boxes.size() == 0)
                begin
                    $error("box beat with no box expected");
                    errors++;
                end
                else
                begin
                    e = expected_boxes.pop_front();
                    if (box_x !== e.bx)
                    begin
                        $error("box_x expected %0d got %0d", e.bx, box_x); errors++;
                    end
                    if (box_y !== e.by)
                    begin
                        $error("box_y expected %0d got %0d", e.by, box_y); errors++;
                    end
                    if (box_width !== e.bw)
                    begin
                        $error("box_width expected %0d got %0d", e.bw, box_width); errors++;
                    end
                    if (box_height !== e.bh)
                    begin
                        $error("box_height expected %0d got %0d", e.bh, box_height); errors++;
                    end
                    if (last_box !== e.lst)
                    begin
                        $error("last_box expected %0d got %0d", e.lst, last_box); errors++;
                    end
                end
            end
            // receiver stalls at random, or holds off for a long counted stretch
            if (hold_reqs != hold_seen)
            begin
                hold_seen <= hold_reqs;
                hold_left <= HoldCycles;
                out_ready <= 1'b0;
            end
            else if (hold_left > 0)
            begin
                hold_left <= hold_left - 1;
                out_ready <= 1'b0;
            end
            else if (rdy_gap > 0)
            begin
                rdy_gap <= rdy_gap - 1;
                out_ready <= 1'b0;
            end
            else
            begin
                out_ready <= 1'b1;
                rdy_gap <= gap_len();
            end
        end
    end

    // watchdog: cycles in which no beat moves on either side
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || !rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= StallLimit)
        begin
            $display("timeout after %0d idle cycles", idle_cycles);
            $display("*** FAILED ***");
            $finish;
        end
    end

    // apb write: setup then access, written while idle only
    task automatic write_mode(logic [1:0] m);
        @(posedge clk);
        psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
        paddr <= RegStackMode; pwdata <= {30'd0, m};
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        mode_shadow = m;
    endtask

    // wait until all requests accepted and all boxes out, then let the block settle
    task automatic drain();
        while (pending_reqs.size() > 0 || in_valid || expected_boxes.size() > 0)
            @(posedge clk);
        repeat (200) @(posedge clk);
    endtask

    task automatic load_directed();
        req_t r;
        // extremes of every coordinate and extent field
        r = '{15'h7FFF, 15'h7FFF, 15'h7FFF, 15'h7FFF, 15'h7FFF, 15'h7FFF, 7'd64, 7'd4, DirN, DirE};
        pending_reqs.push_back(r);
        r = '{15'd0, 15'd0, 15'd0, 15'd0, 15'd0, 15'd0, 7'd1, 7'd3, DirS, DirW};
        pending_reqs.push_back(r);
        // each cut side
        for (int d = 0; d < 4; d++)
        begin
            r = '{15'd100, 15'd200, 15'd1000, 15'd777, 15'd3000, 15'd2000, 7'd5, 7'd5,
                  2'(d), 2'(3 - d)};
            pending_reqs.push_back(r);
        end
        // zero counts give nothing
        r = '{15'd1, 15'd2, 15'd3, 15'd4, 15'd5, 15'd6, 7'd0, 7'd5, DirN, DirS};
        pending_reqs.push_back(r);
        r = '{15'd1, 15'd2, 15'd3, 15'd4, 15'd5, 15'd6, 7'd5, 7'd0, DirN, DirS};
        pending_reqs.push_back(r);
        // too many views, clamped
        r = '{15'd5, 15'd5, 15'd30000, 15'd20000, 15'd100, 15'd100, 7'd127, 7'd127, DirE, DirS};
        pending_reqs.push_back(r);
        // oversized cut under diminish: total extent far above the area
        r = '{15'd10, 15'd10, 15'd20, 15'd20, 15'h7FFF, 15'h7FFF, 7'd2, 7'd2, DirW, DirN};
        pending_reqs.push_back(r);
        // single view takes the whole area
        r = '{15'h4000, 15'h2000, 15'd9, 15'd9, 15'd1, 15'd1, 7'd1, 7'd1, DirN, DirN};
        pending_reqs.push_back(r);
    endtask

    initial
    begin
        logic [1:0] modes[5];
        modes = '{ModeEven, ModeDiminish, ModeDwindle, 2'd3, ModeEven};
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // directed requests under every mode
        for (int m = 0; m < 4; m++)
        begin
            write_mode(modes[m]);
            load_directed();
            drain();
        end

        // backpressure: receiver holds off while the sender keeps offering
        write_mode(ModeDwindle);
        for (int i = 0; i < 6; i++)
            pending_reqs.push_back(rand_req());
        hold_reqs++;
        drain();

        // random requests, switching mode between phases
        for (int ph = 0; ph < 5; ph++)
        begin
            write_mode(ph == 4 ? 2'($urandom_range(3)) : modes[ph]);
            for (int i = 0; i < NumRandom / 5; i++)
                pending_reqs.push_back(rand_req());
            drain();
        end

        $display("sent %0d requests over all stack modes, checked %0d boxes",
                 reqs_sent, boxes_seen);
        if (errors == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end
endmodule
